// File: rtl/link_reconnect_backoff_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for link_reconnect_backoff_scheduler
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINK_RECONNECT_BACKOFF_SCHEDULER_ASSERT_SVH
`define LINK_RECONNECT_BACKOFF_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define LRBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lrbs assertion failed");
`define LRBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error("lrbs assertion failed");
`else
`define LRBS_ASSERT(lbl, clk, rst_n, prop)
`define LRBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lrbs_pkg.sv
// ----------------------------------------------------------------------------
// lrbs_pkg
// Types, codes and constants of the reconnect backoff scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbs_pkg;

    localparam int MAX_NETWORKS  = 8;
    localparam int NET_W         = 3;
    localparam int CNT_W         = 4;
    localparam int TIME_W        = 32;
    localparam int MS_W          = 20;
    localparam int BACKOFF_W     = 21;
    localparam int FAIL_W        = 16;
    localparam int THRESH_W      = 6;
    localparam int FAILS_PER_NET = 3;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;

    localparam logic [MS_W-1:0] RST_CONNECT_TIMEOUT = MS_W'(12000);
    localparam logic [MS_W-1:0] RST_BACKOFF_START   = MS_W'(2000);
    localparam logic [MS_W-1:0] RST_MAX_BACKOFF     = MS_W'(60000);
    localparam logic [MS_W-1:0] RST_STATUS_INTERVAL = MS_W'(2000);
    localparam logic [MS_W-1:0] RST_IDLE_RETRY      = MS_W'(5000);

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_START     = 3'd1,
        ACT_CONNECTED = 3'd2,
        ACT_FAILED    = 3'd3,
        ACT_REFRESH   = 3'd4,
        ACT_NOTHING   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        RSN_NONE      = 2'd0,
        RSN_NOT_FOUND = 2'd1,
        RSN_TIMEOUT   = 2'd2,
        RSN_REJECTED  = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        LNK_OTHER     = 2'd0,
        LNK_CONNECTED = 2'd1,
        LNK_NOT_FOUND = 2'd2,
        LNK_REJECTED  = 2'd3
    } t_link;

    typedef enum logic {
        FN_POLL      = 1'b0,
        FN_RECONNECT = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_SAVED_COUNT     = 3'd0,
        REG_CONNECT_TIMEOUT = 3'd1,
        REG_BACKOFF_START   = 3'd2,
        REG_MAX_BACKOFF     = 3'd3,
        REG_STATUS_INTERVAL = 3'd4,
        REG_IDLE_RETRY      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] saved_count;
        logic [MS_W-1:0]  connect_timeout;
        logic [MS_W-1:0]  backoff_start;
        logic [MS_W-1:0]  max_backoff;
        logic [MS_W-1:0]  status_interval;
        logic [MS_W-1:0]  idle_retry;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mod_step;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic mod_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/lrbs_if.sv
// ----------------------------------------------------------------------------
// lrbs_req_if / lrbs_rsp_if
// Valid/ready channels for poll items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrbs_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] now_ms;
    logic [1:0]  link_status;

    modport source (output valid, output func, output now_ms, output link_status,
                    input ready);
    modport sink   (input valid, input func, input now_ms, input link_status,
                    output ready);
endinterface

interface lrbs_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] network_index;
    logic [1:0] fail_reason;
    logic       drop_link;
    logic       portal_up;
    logic       portal_down;

    modport source (output valid, output action, output network_index,
                    output fail_reason, output drop_link, output portal_up,
                    output portal_down, input ready);
    modport sink   (input valid, input action, input network_index,
                    input fail_reason, input drop_link, input portal_up,
                    input portal_down, output ready);
endinterface

`default_nettype wire

// File: rtl/lrbs_cfg.sv
// ----------------------------------------------------------------------------
// lrbs_cfg
// APB register file holding the scheduler timing and rotation settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbs_cfg (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [lrbs_pkg::ADDR_W-1:0]   paddr,
    input  wire [lrbs_pkg::DATA_W-1:0]   pwdata,
    output logic [lrbs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output lrbs_pkg::t_cfg               o_cfg
);

    lrbs_pkg::t_cfg       r_cfg;
    lrbs_pkg::t_reg_idx   w_idx;
    logic                 w_wr;

    assign w_idx  = lrbs_pkg::t_reg_idx'(paddr[lrbs_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.saved_count     <= '0;
            r_cfg.connect_timeout <= lrbs_pkg::RST_CONNECT_TIMEOUT;
            r_cfg.backoff_start   <= lrbs_pkg::RST_BACKOFF_START;
            r_cfg.max_backoff     <= lrbs_pkg::RST_MAX_BACKOFF;
            r_cfg.status_interval <= lrbs_pkg::RST_STATUS_INTERVAL;
            r_cfg.idle_retry      <= lrbs_pkg::RST_IDLE_RETRY;
        end else if (w_wr) begin
            unique case (w_idx)
                lrbs_pkg::REG_SAVED_COUNT: begin
                    r_cfg.saved_count <= pwdata[lrbs_pkg::CNT_W-1:0];
                end
                lrbs_pkg::REG_CONNECT_TIMEOUT: begin
                    r_cfg.connect_timeout <= pwdata[lrbs_pkg::MS_W-1:0];
                end
                lrbs_pkg::REG_BACKOFF_START: begin
                    r_cfg.backoff_start <= pwdata[lrbs_pkg::MS_W-1:0];
                end
                lrbs_pkg::REG_MAX_BACKOFF: begin
                    r_cfg.max_backoff <= pwdata[lrbs_pkg::MS_W-1:0];
                end
                lrbs_pkg::REG_STATUS_INTERVAL: begin
                    r_cfg.status_interval <= pwdata[lrbs_pkg::MS_W-1:0];
                end
                lrbs_pkg::REG_IDLE_RETRY: begin
                    r_cfg.idle_retry <= pwdata[lrbs_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lrbs_pkg::REG_SAVED_COUNT:     prdata = lrbs_pkg::DATA_W'(r_cfg.saved_count);
            lrbs_pkg::REG_CONNECT_TIMEOUT: prdata = lrbs_pkg::DATA_W'(r_cfg.connect_timeout);
            lrbs_pkg::REG_BACKOFF_START:   prdata = lrbs_pkg::DATA_W'(r_cfg.backoff_start);
            lrbs_pkg::REG_MAX_BACKOFF:     prdata = lrbs_pkg::DATA_W'(r_cfg.max_backoff);
            lrbs_pkg::REG_STATUS_INTERVAL: prdata = lrbs_pkg::DATA_W'(r_cfg.status_interval);
            lrbs_pkg::REG_IDLE_RETRY:      prdata = lrbs_pkg::DATA_W'(r_cfg.idle_retry);
            default:                       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lrbs_dp.sv
// ----------------------------------------------------------------------------
// lrbs_dp
// Scheduler datapath: item latch, timer compares, rotation reduction,
// state update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbs_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lrbs_pkg::t_cfg                     i_cfg,
    input  lrbs_pkg::t_ctrl_cmd                i_cmd,
    output lrbs_pkg::t_dp_sts                  o_sts,
    input  wire                                i_func,
    input  wire [lrbs_pkg::TIME_W-1:0]         i_now_ms,
    input  wire [1:0]                          i_link_status,
    output logic [2:0]                         o_action,
    output logic [lrbs_pkg::NET_W-1:0]         o_network_index,
    output logic [1:0]                         o_fail_reason,
    output logic                               o_drop_link,
    output logic                               o_portal_up,
    output logic                               o_portal_down
);

    // latched item
    lrbs_pkg::t_func                 r_func;
    logic [lrbs_pkg::TIME_W-1:0]     r_now;
    lrbs_pkg::t_link                 r_status;

    // scheduler state
    logic                            r_running;
    logic [lrbs_pkg::FAIL_W-1:0]     r_fail;
    logic [lrbs_pkg::BACKOFF_W-1:0]  r_backoff;
    logic [lrbs_pkg::TIME_W-1:0]     r_retry_at;
    logic [lrbs_pkg::TIME_W-1:0]     r_began;
    logic [lrbs_pkg::TIME_W-1:0]     r_last_refresh;
    logic [lrbs_pkg::NET_W-1:0]      r_rot;
    logic                            r_portal_on;

    // evaluation registers
    logic                            r_timeout;
    logic                            r_refresh_due;
    logic                            r_retry_due;
    logic [lrbs_pkg::NET_W-1:0]      r_idx;

    logic                            n_running;
    logic [lrbs_pkg::FAIL_W-1:0]     n_fail;
    logic [lrbs_pkg::BACKOFF_W-1:0]  n_backoff;
    logic [lrbs_pkg::TIME_W-1:0]     n_retry_at;
    logic [lrbs_pkg::TIME_W-1:0]     n_began;
    logic [lrbs_pkg::TIME_W-1:0]     n_last_refresh;
    logic [lrbs_pkg::NET_W-1:0]      n_rot;
    logic                            n_portal_on;

    lrbs_pkg::t_action               n_action;
    logic [lrbs_pkg::NET_W-1:0]      n_net;
    lrbs_pkg::t_reason               n_reason;
    logic                            n_drop;
    logic                            n_pup;
    logic                            n_pdown;

    logic [lrbs_pkg::CNT_W-1:0]      w_count;
    logic [lrbs_pkg::THRESH_W-1:0]   w_thresh;
    logic [lrbs_pkg::TIME_W-1:0]     w_elapsed;
    logic [lrbs_pkg::TIME_W-1:0]     w_since_refresh;
    logic [lrbs_pkg::CNT_W-1:0]      w_idx_inc;
    logic                            w_record;
    logic [lrbs_pkg::TIME_W-1:0]     w_addend;
    logic [lrbs_pkg::TIME_W-1:0]     w_sum;
    logic [lrbs_pkg::FAIL_W-1:0]     w_fail_inc;

    assign w_count = (i_cfg.saved_count > lrbs_pkg::CNT_W'(lrbs_pkg::MAX_NETWORKS))
                   ? lrbs_pkg::CNT_W'(lrbs_pkg::MAX_NETWORKS) : i_cfg.saved_count;
    assign w_thresh = lrbs_pkg::THRESH_W'(w_count)
                    * lrbs_pkg::THRESH_W'(lrbs_pkg::FAILS_PER_NET);

    assign w_elapsed       = r_now - r_began;
    assign w_since_refresh = r_now - r_last_refresh;

    assign o_sts.mod_busy = (w_count != '0) && (lrbs_pkg::CNT_W'(r_idx) >= w_count);

    assign w_idx_inc  = lrbs_pkg::CNT_W'(r_idx) + lrbs_pkg::CNT_W'(1);
    assign w_fail_inc = (r_fail == '1) ? r_fail : r_fail + lrbs_pkg::FAIL_W'(1);
    assign w_record   = r_running && (r_status != lrbs_pkg::LNK_CONNECTED);
    assign w_addend   = w_record ? lrbs_pkg::TIME_W'(r_backoff)
                                 : lrbs_pkg::TIME_W'(i_cfg.idle_retry);
    assign w_sum      = r_now + w_addend;

    always_comb begin
        n_running      = r_running;
        n_fail         = r_fail;
        n_backoff      = r_backoff;
        n_retry_at     = r_retry_at;
        n_began        = r_began;
        n_last_refresh = r_last_refresh;
        n_rot          = r_rot;
        n_portal_on    = r_portal_on;
        n_action       = lrbs_pkg::ACT_NONE;
        n_net          = '0;
        n_reason       = lrbs_pkg::RSN_NONE;
        n_drop         = 1'b0;
        n_pup          = 1'b0;
        n_pdown        = 1'b0;

        if (r_func == lrbs_pkg::FN_RECONNECT) begin
            n_retry_at = '0;
            n_backoff  = lrbs_pkg::BACKOFF_W'(i_cfg.backoff_start);
            n_running  = 1'b0;
            n_drop     = 1'b1;
        end else if (r_running) begin
            if (r_status == lrbs_pkg::LNK_CONNECTED) begin
                n_running = 1'b0;
                n_fail    = '0;
                n_backoff = lrbs_pkg::BACKOFF_W'(i_cfg.backoff_start);
                n_action  = lrbs_pkg::ACT_CONNECTED;
                if (r_portal_on) begin
                    n_portal_on = 1'b0;
                    n_pdown     = 1'b1;
                end
            end else if (r_timeout || r_status == lrbs_pkg::LNK_REJECTED) begin
                n_action = lrbs_pkg::ACT_FAILED;
                if (r_timeout) begin
                    n_reason = (r_status == lrbs_pkg::LNK_NOT_FOUND)
                             ? lrbs_pkg::RSN_NOT_FOUND : lrbs_pkg::RSN_TIMEOUT;
                end else begin
                    n_reason = lrbs_pkg::RSN_REJECTED;
                end
                n_running  = 1'b0;
                n_fail     = w_fail_inc;
                n_retry_at = w_sum;
                if (r_backoff >= lrbs_pkg::BACKOFF_W'(i_cfg.max_backoff)) begin
                    n_backoff = lrbs_pkg::BACKOFF_W'(i_cfg.max_backoff);
                end else begin
                    n_backoff = {r_backoff[lrbs_pkg::BACKOFF_W-2:0], 1'b0};
                end
                if (!r_portal_on && w_count != '0
                    && w_fail_inc >= lrbs_pkg::FAIL_W'(w_thresh)) begin
                    n_portal_on = 1'b1;
                    n_pup       = 1'b1;
                end
            end
        end else if (r_status == lrbs_pkg::LNK_CONNECTED) begin
            if (r_refresh_due) begin
                n_last_refresh = r_now;
                n_action       = lrbs_pkg::ACT_REFRESH;
            end
        end else if (r_retry_due) begin
            if (w_count == '0) begin
                n_retry_at = w_sum;
                n_action   = lrbs_pkg::ACT_NOTHING;
                if (!r_portal_on) begin
                    n_portal_on = 1'b1;
                    n_pup       = 1'b1;
                end
            end else begin
                n_rot     = (w_idx_inc == w_count) ? '0 : w_idx_inc[lrbs_pkg::NET_W-1:0];
                n_running = 1'b1;
                n_began   = r_now;
                n_action  = lrbs_pkg::ACT_START;
                n_net     = r_idx;
                n_drop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= lrbs_pkg::t_func'(i_func);
            r_now    <= i_now_ms;
            r_status <= lrbs_pkg::t_link'(i_link_status);
        end
        if (i_cmd.eval) begin
            r_timeout     <= w_elapsed > lrbs_pkg::TIME_W'(i_cfg.connect_timeout);
            r_refresh_due <= w_since_refresh > lrbs_pkg::TIME_W'(i_cfg.status_interval);
            r_retry_due   <= r_now >= r_retry_at;
            r_idx         <= r_rot;
        end else if (i_cmd.mod_step) begin
            r_idx <= r_idx - w_count[lrbs_pkg::NET_W-1:0];
        end
        if (i_cmd.commit) begin
            o_action        <= n_action;
            o_network_index <= n_net;
            o_fail_reason   <= n_reason;
            o_drop_link     <= n_drop;
            o_portal_up     <= n_pup;
            o_portal_down   <= n_pdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_fail         <= '0;
            r_backoff      <= lrbs_pkg::BACKOFF_W'(lrbs_pkg::RST_BACKOFF_START);
            r_retry_at     <= '0;
            r_began        <= '0;
            r_last_refresh <= '0;
            r_rot          <= '0;
            r_portal_on    <= 1'b0;
        end else if (i_cmd.commit) begin
            r_running      <= n_running;
            r_fail         <= n_fail;
            r_backoff      <= n_backoff;
            r_retry_at     <= n_retry_at;
            r_began        <= n_began;
            r_last_refresh <= n_last_refresh;
            r_rot          <= n_rot;
            r_portal_on    <= n_portal_on;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lrbs_ctrl.sv
// ----------------------------------------------------------------------------
// lrbs_ctrl
// Item sequencer: capture, evaluate, rotation reduce, commit into the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_reconnect_backoff_scheduler_assert.svh"

module lrbs_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output lrbs_pkg::t_ctrl_cmd   o_cmd,
    input  lrbs_pkg::t_dp_sts     i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.mod_step = (r_state == S_MOD) && i_sts.mod_busy;
        o_cmd.commit   = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (!i_sts.mod_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `LRBS_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(o_cmd))
    `LRBS_ASSERT_NEXT(a_commit_loads, i_clk, i_rst_n, o_cmd.commit, r_out_valid && o_in_ready)
    `LRBS_ASSERT_NEXT(a_finish_holds, i_clk, i_rst_n, (r_state == S_FINISH) && !o_cmd.commit, (r_state == S_FINISH) && r_out_valid)
    `LRBS_ASSERT_NEXT(a_capture_busy, i_clk, i_rst_n, o_cmd.capture, !o_in_ready)

endmodule

`default_nettype wire

// File: rtl/link_reconnect_backoff_scheduler.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_scheduler
// Reconnect scheduler with exponential backoff and round-robin network
// rotation, APB configured.
//
//   channel   dir   handshake          payload
//   i_req     in    valid/ready        func, now_ms, link_status
//   o_rsp     out   valid/ready        action, network_index, fail_reason,
//                                      drop_link, portal_up, portal_down
//   apb       in    psel/penable       paddr, pwdata, prdata
//
// Items are captured, evaluated, rotation reduced (at most 7 steps, when
// the saved count shrank to or below the stored position) and committed.
// The result register frees the input side: a new item is taken while a
// result waits; commit stalls only until that result is taken.
// Synchronous active-low reset restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module link_reconnect_backoff_scheduler (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    lrbs_req_if.sink                     i_req,
    lrbs_rsp_if.source                   o_rsp,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [lrbs_pkg::ADDR_W-1:0]   paddr,
    input  wire [lrbs_pkg::DATA_W-1:0]   pwdata,
    output logic [lrbs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    lrbs_pkg::t_cfg       w_cfg;
    lrbs_pkg::t_ctrl_cmd  w_cmd;
    lrbs_pkg::t_dp_sts    w_sts;
    logic                 w_in_ready;
    logic                 w_out_valid;

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    lrbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lrbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lrbs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_func          (i_req.func),
        .i_now_ms        (i_req.now_ms),
        .i_link_status   (i_req.link_status),
        .o_action        (o_rsp.action),
        .o_network_index (o_rsp.network_index),
        .o_fail_reason   (o_rsp.fail_reason),
        .o_drop_link     (o_rsp.drop_link),
        .o_portal_up     (o_rsp.portal_up),
        .o_portal_down   (o_rsp.portal_down)
    );

endmodule

`default_nettype wire
